### rtl/sidec_pkg.sv
// sidec_pkg: shared types and constants for the signed decimal printer
// depends on nothing; used by signed_int_to_decimal_ascii and sidec_check
package sidec_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned DIGIT_SLOTS = 10;
   localparam int unsigned BCD_W       = DIGIT_W * DIGIT_SLOTS;
   localparam int unsigned BIT_CNT_W   = 5;
   localparam int unsigned DIG_CNT_W   = 4;
   localparam int unsigned CHAR_W      = 8;

   localparam logic [CHAR_W-1:0]    ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0]    ASCII_MINUS = 8'h2D;
   localparam logic [BIT_CNT_W-1:0] LAST_BIT    = 5'd31;
   localparam logic [DIG_CNT_W-1:0] FULL_COUNT  = 4'd10;
   localparam logic [DIG_CNT_W-1:0] ONE_DIGIT   = 4'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // double-dabble correction: a digit of five or more gets three added before the shift
   function automatic logic [DIGIT_W-1:0] dabble_adjust(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W-1:0] r;
      r = (d >= 4'd5) ? d + 4'd3 : d;
      return r;
   endfunction

endpackage

### rtl/signed_int_to_decimal_ascii.sv
// signed_int_to_decimal_ascii: prints a two's complement word as decimal ascii text
// depends on sidec_pkg
//
// One word is taken when start is high and busy is low. The block then prints
// it as signed decimal text, one character per beat, most significant digit
// first, with a leading '-' for a negative value; rsp_last marks the final
// character. Zero prints "0" and the most negative value prints
// "-2147483648". Each character is on rsp_char_out for exactly one cycle with
// rsp_valid high and the receiver must take it then: there is no back-pressure.
// Sequence: after the accepting edge the word is converted bit-serially by a
// double-dabble shift register, one magnitude bit per cycle; then leading zero
// digits are dropped one digit per cycle, and the characters follow one per
// cycle. Busy lasts equally long whatever the number of digits, and longer for
// a negative word by its sign character; a new word is taken only once busy is low.
module signed_int_to_decimal_ascii
   import sidec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [WORD_W-1:0] req_word,
   output logic              rsp_valid,
   output logic [CHAR_W-1:0] rsp_char_out,
   output logic              rsp_last
);

   // control state
   state_type state_ff, state_in;

   // datapath registers: magnitude shifter, bcd digit store, counters, sign
   logic [WORD_W-1:0]    mag_ff, mag_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic                 neg_ff, neg_in;

   logic                 accept;
   logic [DIGIT_W-1:0]   top_digit;
   logic [BCD_W-1:0]     bcd_adj;
   logic                 skip_more;

   assign accept    = start && (state_ff == ST_IDLE);
   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];
   // a leading zero is dropped while more than one digit is left
   assign skip_more = (top_digit == '0) && (dig_cnt_ff != ONE_DIGIT);

   // per-digit correction before each shift, all digits in parallel
   always_comb begin
      for (int k = 0; k < DIGIT_SLOTS; k++) begin
         bcd_adj[k*DIGIT_W +: DIGIT_W] = dabble_adjust(bcd_ff[k*DIGIT_W +: DIGIT_W]);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (bit_cnt_ff == '0) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (!skip_more) state_in = neg_ff ? ST_SIGN : ST_EMIT;
         end
         ST_SIGN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (dig_cnt_ff == ONE_DIGIT) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      neg_in     = neg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // two's complement magnitude; the most negative value maps onto itself
               neg_in     = req_word[WORD_W-1];
               mag_in     = req_word[WORD_W-1] ? (~req_word + 1'b1) : req_word;
               bcd_in     = '0;
               bit_cnt_in = LAST_BIT;
            end
         end
         ST_CONV: begin
            // shift one magnitude bit into the corrected bcd register
            bcd_in     = {bcd_adj[BCD_W-2:0], mag_ff[WORD_W-1]};
            mag_in     = {mag_ff[WORD_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 1'b1;
            dig_cnt_in = FULL_COUNT;
         end
         ST_SKIP: begin
            if (skip_more) begin
               bcd_in     = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end
         end
         ST_SIGN: begin
         end
         ST_EMIT: begin
            bcd_in     = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            dig_cnt_in = dig_cnt_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
         dig_cnt_ff <= '0;
         neg_ff     <= 1'b0;
         mag_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
         neg_ff     <= neg_in;
         mag_ff     <= mag_in;
      end
   end

   // digit store has no reset: every digit is written before it is read
   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
   end

   // outputs
   always_comb begin
      busy         = (state_ff != ST_IDLE);
      rsp_valid    = 1'b0;
      rsp_char_out = ASCII_ZERO;
      rsp_last     = 1'b0;
      unique case (state_ff)
         ST_SIGN: begin
            rsp_valid    = 1'b1;
            rsp_char_out = ASCII_MINUS;
         end
         ST_EMIT: begin
            rsp_valid    = 1'b1;
            rsp_char_out = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
            rsp_last     = (dig_cnt_ff == ONE_DIGIT);
         end
         ST_IDLE, ST_CONV, ST_SKIP: begin
         end
         default: begin
         end
      endcase
   end

endmodule

### rtl/sidec_check.sv
// sidec_check: port-level checks for signed_int_to_decimal_ascii
// depends on sidec_pkg; bound to the top level at the end of this file
module sidec_check
   import sidec_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [CHAR_W-1:0] rsp_char_out,
   input logic              rsp_last
);

   // characters only appear while a word is in hand
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("character beat outside a busy period");

   // an accepted word makes the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // the run ends on its final character
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> (!rsp_valid && !busy))
      else $error("beat or busy after the final character");

   // a sign is always followed by at least one digit
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_char_out == ASCII_MINUS) |-> !rsp_last)
      else $error("sign flagged as final character");

endmodule

bind signed_int_to_decimal_ascii sidec_check u_sidec_check (.*);
